### rtl/core/lant_pkg.sv
// Shared constants, types and codes for the Langton's ant grid step unit.
`timescale 1ns / 1ps
`default_nettype none

package lant_pkg;

  // Grid store geometry
  localparam int GRID_DIM = 64;
  localparam int COORD_W  = $clog2(GRID_DIM);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int SIZE_W   = COORD_W + 1;
  localparam int CELL_W   = 32;

  // Ant table geometry
  localparam int MAX_ANTS = 4;
  localparam int ANT_W    = $clog2(MAX_ANTS);
  localparam int CNT_W    = ANT_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANT_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANT_COLOR     = 3'd5;

  // Register reset values
  localparam logic [SIZE_W-1:0]  GRID_SIZE_RST     = 7'd50;
  localparam logic [2:0]         ANT_COUNT_RST     = 3'd1;
  localparam logic [1:0]         START_HEADING_RST = 2'd2;
  localparam logic [CELL_W-1:0]  ANT_COLOR_RST     = 32'd255;

  // Opcodes and result kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_READ   = 1'b1;
  localparam logic KIND_ANT  = 1'b0;
  localparam logic KIND_CELL = 1'b1;

  // Headings
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ANT,
    S_ANT_DATA
  } state_t;

  // Grid RAM access: one write request and one read request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/core/lant_grid_ram.sv
// Grid cell store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lant_grid_ram
  import lant_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_req_t          req,
  output logic      [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [GRID_DIM*GRID_DIM];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/langton_ant_grid_step_unit.sv
// Top level: Langton's ant sequencer over a cleared toroidal grid store.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake          | word
// ---------+--------------------+---------------------------------------------
// in       | in_valid/in_ready  | opcode, read_x, read_y
// out      | out_valid/out_ready| result_kind, ant_index, ant_col, ant_row,
//          |                    | ant_dir, cell_value, last
// cfg      | cfg_we             | cfg_index, cfg_data
//
// After reset the grid RAM is swept to zero, one cell a cycle, with in_ready
// low. A cell read takes a RAM read, then the result goes to the output
// register. A tick visits each ant in turn: on its first tick an ant only
// takes the start values; an active ant takes a RAM read, then modify and
// write back. A stalled output register holds the sequencer in place.

module langton_ant_grid_step_unit
  import lant_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input words
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic [COORD_W-1:0]    read_x,
  input  wire logic [COORD_W-1:0]    read_y,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       result_kind,
  output logic      [ANT_W-1:0]      ant_index,
  output logic      [COORD_W-1:0]    ant_col,
  output logic      [COORD_W-1:0]    ant_row,
  output logic      [1:0]            ant_dir,
  output logic      [CELL_W-1:0]     cell_value,
  output logic                       last,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [SIZE_W-1:0]  grid_size;
  logic [2:0]         ant_count;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [1:0]         start_heading;
  logic [CELL_W-1:0]  ant_color;

  // Sequencer state
  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ANT_W-1:0]   idx;

  // Ant table
  logic [COORD_W-1:0] ant_x_pos   [MAX_ANTS];
  logic [COORD_W-1:0] ant_y_pos   [MAX_ANTS];
  logic [1:0]         ant_heading [MAX_ANTS];
  logic [MAX_ANTS-1:0] ant_active;

  // RAM
  ram_req_t           mem_req;
  logic [CELL_W-1:0]  rd_data;

  // Combinational control
  logic               out_free;
  logic               emit;
  logic               ant_load;
  logic               ant_step;
  logic               res_kind;
  logic [COORD_W-1:0] res_col;
  logic [COORD_W-1:0] res_row;
  logic [1:0]         res_dir;
  logic [CELL_W-1:0]  res_cell;
  logic               res_last;

  // Datapath values
  logic [SIZE_W-1:0]  size_use;
  logic [2:0]         ants_use;
  logic               ant_last;
  logic [COORD_W-1:0] start_x_w;
  logic [COORD_W-1:0] start_y_w;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               cell_set;
  logic [1:0]         head_new;
  logic [COORD_W-1:0] x_new;
  logic [COORD_W-1:0] y_new;
  logic [COORD_W-1:0] x_inc;
  logic [COORD_W-1:0] x_dec;
  logic [COORD_W-1:0] y_inc;
  logic [COORD_W-1:0] y_dec;

  lant_grid_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Coordinate at or beyond the grid folds to zero
  function automatic logic [COORD_W-1:0] wrap_coord(
    input logic [COORD_W-1:0] v,
    input logic [SIZE_W-1:0]  size
  );
    return ({1'b0, v} >= size) ? '0 : v;
  endfunction

  // Step toward higher coordinate, wrapping at the edge
  function automatic logic [COORD_W-1:0] step_up(
    input logic [COORD_W-1:0] p,
    input logic [SIZE_W-1:0]  size
  );
    return (({1'b0, p} + SIZE_W'(1)) >= size) ? '0 : p + COORD_W'(1);
  endfunction

  // Step toward lower coordinate, wrapping at the edge
  function automatic logic [COORD_W-1:0] step_down(
    input logic [COORD_W-1:0] p,
    input logic [SIZE_W-1:0]  size
  );
    logic [SIZE_W-1:0] top;
    top = size - SIZE_W'(1);
    return (p == '0) ? top[COORD_W-1:0] : p - COORD_W'(1);
  endfunction

  // Clamp configuration to usable ranges
  always_comb begin
    if (grid_size == '0) begin
      size_use = SIZE_W'(1);
    end else if (grid_size > SIZE_W'(GRID_DIM)) begin
      size_use = SIZE_W'(GRID_DIM);
    end else begin
      size_use = grid_size;
    end
    if (ant_count == '0) begin
      ants_use = 3'd1;
    end else if (ant_count > 3'(MAX_ANTS)) begin
      ants_use = 3'(MAX_ANTS);
    end else begin
      ants_use = ant_count;
    end
  end

  assign ant_last  = (({1'b0, idx} + CNT_W'(1)) == CNT_W'(ants_use));
  assign start_x_w = wrap_coord(start_x, size_use);
  assign start_y_w = wrap_coord(start_y, size_use);
  assign cur_x     = wrap_coord(ant_x_pos[idx], size_use);
  assign cur_y     = wrap_coord(ant_y_pos[idx], size_use);

  // Turn and move of the current ant
  assign cell_set = (rd_data != '0);
  assign head_new = cell_set ? ant_heading[idx] - 2'd1 : ant_heading[idx] + 2'd1;
  assign x_inc    = step_up(cur_x, size_use);
  assign x_dec    = step_down(cur_x, size_use);
  assign y_inc    = step_up(cur_y, size_use);
  assign y_dec    = step_down(cur_y, size_use);

  always_comb begin
    x_new = cur_x;
    y_new = cur_y;
    unique case (head_new)
      HEAD_UP:    y_new = y_dec;
      HEAD_RIGHT: x_new = x_inc;
      HEAD_DOWN:  y_new = y_inc;
      HEAD_LEFT:  x_new = x_dec;
      default:    x_new = cur_x;
    endcase
  end

  assign out_free = !out_valid || out_ready;

  // Next state, RAM accesses and result word
  always_comb begin
    state_next = state;
    mem_req    = '0;
    in_ready   = 1'b0;
    emit       = 1'b0;
    ant_load   = 1'b0;
    ant_step   = 1'b0;
    res_kind   = KIND_ANT;
    res_col    = '0;
    res_row    = '0;
    res_dir    = '0;
    res_cell   = '0;
    res_last   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
        if (clr_addr == {ADDR_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_READ) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {read_y, read_x};
            state_next    = S_READ;
          end else begin
            state_next = S_ANT;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          emit       = 1'b1;
          res_kind   = KIND_CELL;
          res_cell   = rd_data;
          res_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ANT: begin
        if (!ant_active[idx]) begin
          // first tick: take the start values only
          if (out_free) begin
            emit       = 1'b1;
            ant_load   = 1'b1;
            res_col    = start_x_w;
            res_row    = start_y_w;
            res_dir    = start_heading;
            res_last   = ant_last;
            state_next = ant_last ? S_IDLE : S_ANT;
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = {cur_y, cur_x};
          state_next    = S_ANT_DATA;
        end
      end
      S_ANT_DATA: begin
        if (out_free) begin
          emit          = 1'b1;
          ant_step      = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.waddr = {cur_y, cur_x};
          mem_req.wdata = cell_set ? '0 : ant_color;
          res_col       = x_new;
          res_row       = y_new;
          res_dir       = head_new;
          res_last      = ant_last;
          state_next    = ant_last ? S_IDLE : S_ANT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      idx      <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (in_valid && in_ready) begin
        idx <= '0;
      end else if (emit && !res_last) begin
        idx <= idx + ANT_W'(1);
      end
    end
  end

  // Ant table
  always_ff @(posedge clk) begin
    if (rst) begin
      ant_active <= '0;
    end else if (ant_load) begin
      ant_active[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ant_load) begin
      ant_x_pos[idx]   <= start_x_w;
      ant_y_pos[idx]   <= start_y_w;
      ant_heading[idx] <= start_heading;
    end else if (ant_step) begin
      ant_x_pos[idx]   <= x_new;
      ant_y_pos[idx]   <= y_new;
      ant_heading[idx] <= head_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= res_kind;
      ant_index   <= (res_kind == KIND_ANT) ? idx : '0;
      ant_col     <= res_col;
      ant_row     <= res_row;
      ant_dir     <= res_dir;
      cell_value  <= res_cell;
      last        <= res_last;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= GRID_SIZE_RST;
      ant_count     <= ANT_COUNT_RST;
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= START_HEADING_RST;
      ant_color     <= ANT_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIZE:     grid_size     <= cfg_data[SIZE_W-1:0];
        CFG_ANT_COUNT:     ant_count     <= cfg_data[2:0];
        CFG_START_X:       start_x       <= cfg_data[COORD_W-1:0];
        CFG_START_Y:       start_y       <= cfg_data[COORD_W-1:0];
        CFG_START_HEADING: start_heading <= cfg_data[1:0];
        CFG_ANT_COLOR:     ant_color     <= cfg_data[CELL_W-1:0];
        default:           ant_color     <= ant_color;
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/tb_langton_ant_grid_step_unit.sv
// Self-checking testbench for the Langton's ant grid step unit.
`timescale 1ns / 1ps

module tb_langton_ant_grid_step_unit;
  import lant_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 25;

  // One result word as the block reports it
  typedef struct packed {
    logic               kind;
    logic [ANT_W-1:0]   idx;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [1:0]         dir;
    logic [CELL_W-1:0]  value;
    logic               last;
  } ant_word_t;

  // One row of the directed plan: a register write or an input word
  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  op;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic                  typed;
    ant_word_t             want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_TICK;
  logic [COORD_W-1:0]    read_x = '0;
  logic [COORD_W-1:0]    read_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  result_kind;
  logic [ANT_W-1:0]      ant_index;
  logic [COORD_W-1:0]    ant_col;
  logic [COORD_W-1:0]    ant_row;
  logic [1:0]            ant_dir;
  logic [CELL_W-1:0]     cell_value;
  logic                  last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  langton_ant_grid_step_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .read_x      (read_x),
    .read_y      (read_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .ant_index   (ant_index),
    .ant_col     (ant_col),
    .ant_row     (ant_row),
    .ant_dir     (ant_dir),
    .cell_value  (cell_value),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block: registers, grid store and ant table
  logic [SIZE_W-1:0]  size_reg;
  logic [2:0]         count_reg;
  logic [COORD_W-1:0] sx_reg;
  logic [COORD_W-1:0] sy_reg;
  logic [1:0]         head_reg;
  logic [CELL_W-1:0]  color_reg;
  logic [CELL_W-1:0]  grid_mem [GRID_DIM*GRID_DIM];
  logic [COORD_W-1:0] ant_x [MAX_ANTS];
  logic [COORD_W-1:0] ant_y [MAX_ANTS];
  logic [1:0]         ant_h [MAX_ANTS];
  logic               ant_on [MAX_ANTS];

  ant_word_t pending_words [$];
  plan_row_t plan [$];

  int  error_count = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  long_hold_req = 1'b0;
  bit  idle_on = 1'b1;

  function automatic int unsigned live_size();
    int unsigned s;
    s = size_reg;
    if (s == 0) s = 1;
    if (s > GRID_DIM) s = GRID_DIM;
    return s;
  endfunction

  function automatic int unsigned live_ants();
    int unsigned n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > MAX_ANTS) n = MAX_ANTS;
    return n;
  endfunction

  // A coordinate at or past the edge of the grid in use folds to 0
  function automatic logic [COORD_W-1:0] fold_coord(logic [COORD_W-1:0] v, int unsigned sz);
    return (v >= sz) ? '0 : v;
  endfunction

  function automatic ant_word_t ant_report(int unsigned i, logic [COORD_W-1:0] c,
                                           logic [COORD_W-1:0] r, logic [1:0] d, logic l);
    ant_word_t w;
    w = '0;
    w.kind = KIND_ANT;
    w.idx = i[ANT_W-1:0];
    w.col = c;
    w.row = r;
    w.dir = d;
    w.last = l;
    return w;
  endfunction

  function automatic ant_word_t cell_answer(logic [CELL_W-1:0] v);
    ant_word_t w;
    w = '0;
    w.kind = KIND_CELL;
    w.value = v;
    w.last = 1'b1;
    return w;
  endfunction

  // Run one accepted word through the mirror and queue what it yields.
  // A typed row stands in its expected word for every result of that word.
  function automatic void step_colony(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic typed, ant_word_t want);
    int unsigned sz, n, i, cx, cy, addr;
    logic [1:0] h;
    ant_word_t w;
    sz = live_size();
    n = live_ants();
    if (op == OP_READ) begin
      w = cell_answer(grid_mem[y * GRID_DIM + x]);
      pending_words.push_back(typed ? want : w);
    end else begin
      for (i = 0; i < n; i++) begin
        if (!ant_on[i]) begin
          // first tick only wakes the ant at the start registers
          ant_x[i] = fold_coord(sx_reg, sz);
          ant_y[i] = fold_coord(sy_reg, sz);
          ant_h[i] = head_reg;
          ant_on[i] = 1'b1;
        end else begin
          cx = fold_coord(ant_x[i], sz);
          cy = fold_coord(ant_y[i], sz);
          addr = cy * GRID_DIM + cx;
          h = ant_h[i];
          if (grid_mem[addr] != '0) begin
            grid_mem[addr] = '0;
            h = h - 2'd1;
          end else begin
            grid_mem[addr] = color_reg;
            h = h + 2'd1;
          end
          ant_h[i] = h;
          case (h)
            HEAD_UP:    cy = (cy == 0) ? sz - 1 : cy - 1;
            HEAD_RIGHT: cx = (cx + 1 >= sz) ? 0 : cx + 1;
            HEAD_DOWN:  cy = (cy + 1 >= sz) ? 0 : cy + 1;
            default:    cx = (cx == 0) ? sz - 1 : cx - 1;
          endcase
          ant_x[i] = cx[COORD_W-1:0];
          ant_y[i] = cy[COORD_W-1:0];
        end
        w = ant_report(i, ant_x[i], ant_y[i], ant_h[i], i == n - 1);
        pending_words.push_back(typed ? want : w);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Drive one input word and wait for the handshake
  task automatic send_word(input logic op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic typed, input ant_word_t want);
    if (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid <= 1'b1;
    opcode <= op;
    read_x <= x;
    read_y <= y;
    do @(posedge clk); while (!in_ready);
    step_colony(op, x, y, typed, want);
    words_sent++;
  endtask

  // Hold input off until every pending result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_we after a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_GRID_SIZE:     size_reg = val[SIZE_W-1:0];
      CFG_ANT_COUNT:     count_reg = val[2:0];
      CFG_START_X:       sx_reg = val[COORD_W-1:0];
      CFG_START_Y:       sy_reg = val[COORD_W-1:0];
      CFG_START_HEADING: head_reg = val[1:0];
      CFG_ANT_COLOR:     color_reg = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic void plan_word(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.x = x;
    r.y = y;
    plan.push_back(r);
  endfunction

  function automatic void plan_typed(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     ant_word_t want);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.x = x;
    r.y = y;
    r.typed = 1'b1;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(2, 8);
      6:                return $urandom_range(9, GRID_DIM);
      7:                return $urandom_range(1);
      8:                return GRID_DIM;
      default:          return $urandom_range(GRID_DIM + 1, 127);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_color();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_words.size());
      $display("tb_langton_ant_grid_step_unit: done, errors");
      $finish;
    end
  end

  // Result side: check accepted words, then pick next out_ready
  initial begin
    ant_word_t got, want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {result_kind, ant_index, ant_col, ant_row, ant_dir, cell_value, last};
        results_seen++;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got %h", $time, got);
          error_count++;
        end else begin
          want = pending_words.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("ant_index", want.idx, got.idx);
          check_field("ant_col", want.col, got.col);
          check_field("ant_row", want.row, got.row);
          check_field("ant_dir", want.dir, got.dir);
          check_field("cell_value", want.value, got.value);
          check_field("last", want.last, got.last);
        end
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 35);
      end
    end
  end

  // Stimulus
  initial begin
    int k, p, j;
    bit reg_open;
    logic rop;
    logic [COORD_W-1:0] rx, ry;

    size_reg = GRID_SIZE_RST;
    count_reg = ANT_COUNT_RST;
    sx_reg = '0;
    sy_reg = '0;
    head_reg = START_HEADING_RST;
    color_reg = ANT_COLOR_RST;
    for (k = 0; k < GRID_DIM * GRID_DIM; k++) grid_mem[k] = '0;
    for (k = 0; k < MAX_ANTS; k++) begin
      ant_x[k] = '0;
      ant_y[k] = '0;
      ant_h[k] = START_HEADING_RST;
      ant_on[k] = 1'b0;
    end

    // Directed plan, starting from reset defaults (grid 50, one ant, heading down)
    plan_typed(OP_READ, 0, 0, cell_answer('0));
    plan_typed(OP_READ, 63, 63, cell_answer('0));
    plan_typed(OP_TICK, 0, 0, ant_report(0, 0, 0, HEAD_DOWN, 1'b1));
    plan_word(OP_TICK, 0, 0);
    plan_typed(OP_READ, 0, 0, cell_answer(ANT_COLOR_RST));
    // zero colour: marking leaves the cell clear
    plan_reg(CFG_ANT_COLOR, '0);
    plan_word(OP_TICK, 0, 0);
    plan_typed(OP_READ, 49, 0, cell_answer('0));
    plan_reg(CFG_ANT_COLOR, '1);
    plan_reg(CFG_ANT_COUNT, 0);
    plan_word(OP_TICK, 0, 0);
    // oversized grid acts as full store; new ant wakes in the far corner
    plan_reg(CFG_GRID_SIZE, 127);
    plan_reg(CFG_START_X, 63);
    plan_reg(CFG_START_Y, 63);
    plan_reg(CFG_START_HEADING, HEAD_LEFT);
    plan_reg(CFG_ANT_COUNT, 2);
    plan_word(OP_TICK, 0, 0);
    plan_word(OP_TICK, 0, 0);
    // shrink: starts past the edge fold to 0, stranded ants fold in too
    plan_reg(CFG_GRID_SIZE, 40);
    plan_reg(CFG_ANT_COUNT, 7);
    plan_word(OP_TICK, 0, 0);
    plan_word(OP_TICK, 0, 0);
    plan_reg(CFG_GRID_SIZE, 2);
    plan_word(OP_TICK, 0, 0);
    plan_word(OP_TICK, 0, 0);
    plan_word(OP_READ, 63, 63);
    plan_reg(CFG_GRID_SIZE, 0);
    plan_word(OP_TICK, 0, 0);
    plan_word(OP_TICK, 0, 0);
    plan_reg(CFG_GRID_SIZE, GRID_DIM);
    plan_reg(CFG_ANT_COUNT, MAX_ANTS);
    plan_word(OP_TICK, 0, 0);
    plan_word(OP_READ, 0, 0);
    plan_word(OP_READ, 63, 0);
    plan_word(OP_READ, 0, 63);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // wait out the grid clearing sweep
    do @(posedge clk); while (!in_ready);

    reg_open = 1'b0;
    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].is_reg) begin
        if (!reg_open) settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
        reg_open = 1'b1;
      end else begin
        if (reg_open) cfg_we <= 1'b0;
        reg_open = 1'b0;
        send_word(plan[k].op, plan[k].x, plan[k].y, plan[k].typed, plan[k].want);
      end
    end

    // Random phases, each under a fresh register setting
    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_reg(CFG_GRID_SIZE, pick_size());
      write_reg(CFG_ANT_COUNT, $urandom_range(7));
      if ($urandom_range(1)) begin
        write_reg(CFG_START_X, $urandom_range(63));
        write_reg(CFG_START_Y, $urandom_range(7));
        write_reg(CFG_START_HEADING, $urandom_range(3));
      end
      write_reg(CFG_ANT_COLOR, pick_color());
      cfg_we <= 1'b0;
      idle_on = !(p == 2 || p == 5);
      if (p == 2) long_hold_req = 1'b1;
      for (j = 0; j < PHASE_WORDS; j++) begin
        rop = ($urandom_range(99) < 35) ? OP_READ : OP_TICK;
        if ($urandom_range(3) != 0) begin
          rx = COORD_W'($urandom_range(live_size() - 1));
          ry = COORD_W'($urandom_range(live_size() - 1));
        end else begin
          rx = COORD_W'($urandom_range(63));
          ry = COORD_W'($urandom_range(63));
        end
        send_word(rop, rx, ry, 1'b0, '0);
      end
    end
    idle_on = 1'b1;

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Sent %0d input words, checked %0d result words, %0d register writes.",
             words_sent, results_seen, reg_writes);
    $display("Covered grid sizes 0 to 127, one to four ants, zero and full colours, long stall.");
    if (error_count == 0) begin
      $display("tb_langton_ant_grid_step_unit: done, clean");
    end else begin
      $display("tb_langton_ant_grid_step_unit: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lant_pkg.sv
rtl/core/lant_grid_ram.sv
rtl/core/langton_ant_grid_step_unit.sv
verif/tb_langton_ant_grid_step_unit.sv
